### sv/ordered_set_table_defines.svh
// assertion macros for the ordered set table checker
`ifndef ORDERED_SET_TABLE_DEFINES_SVH
`define ORDERED_SET_TABLE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define OSET_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered set table check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define OSET_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered set table check failed");

`endif

### sv/oset_pkg.sv
// shared constants, codes and types of the ordered set table
package oset_pkg;

    localparam int CAPACITY    = 16;
    localparam int ELEM_WIDTH  = 32;
    localparam int VALUE_W     = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic                  capture;
        logic                  add_en;
        logic                  rem_en;
        logic [CNT_W-1:0]      count;
        logic [ELEM_WIDTH-1:0] key;
    } t_cell_ctl;

endpackage

### sv/oset_if.sv
// valid/ready channels of the ordered set table
interface oset_in_if;
    import oset_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
    modport monitor (input valid, input cmd, input value, input ready);
endinterface

interface oset_out_if;
    import oset_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   is_empty;

    modport source (output valid, output status, output entry_count, output is_empty,
                    input ready);
    modport sink (input valid, input status, input entry_count, input is_empty,
                  output ready);
    modport monitor (input valid, input status, input entry_count, input is_empty,
                     input ready);
endinterface

### sv/oset_cell.sv
// one table cell: holds an entry, compares it, shifts from its upper neighbor
module oset_cell import oset_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [ELEM_WIDTH-1:0] i_next_value,
    input  logic                  i_seen,
    output logic [ELEM_WIDTH-1:0] o_value,
    output logic                  o_seen
);

    logic [ELEM_WIDTH-1:0] r_value;
    logic                  r_hit;
    logic                  in_use;

    assign in_use  = CNT_W'(i_index) < i_ctl.count;
    assign o_seen  = i_seen | r_hit;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.capture) begin
            r_hit <= in_use && (r_value == i_ctl.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.add_en && (CNT_W'(i_index) == i_ctl.count)) begin
            r_value <= i_ctl.key;
        end else if (i_ctl.rem_en && o_seen) begin
            r_value <= i_next_value;
        end
    end

endmodule

### sv/ordered_set_table.sv
// the result is registered in the execute state, after the input is accepted
// one transaction at a time; cells register their compare
// on accept, the execute state updates the cell row and loads the result
// a result waiting on the output holds the update until it is taken
// reset clears the entry count and control; held entries are not cleared
module ordered_set_table import oset_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oset_in_if.sink    i_in,
    oset_out_if.source o_out
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [ELEM_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]      r_count;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_out_empty;

    t_status               n_status;
    logic [CNT_W-1:0]      n_count;
    logic                  in_fire;
    logic                  exec_go;
    logic                  any_hit;
    logic                  do_add;
    logic                  do_rem;
    t_cell_ctl             cell_ctl;

    logic [ELEM_WIDTH-1:0] cell_value [CAPACITY];
    logic [ELEM_WIDTH-1:0] cell_next  [CAPACITY];
    logic [CAPACITY:0]     seen;

    assign i_in.ready = (r_state == S_IDLE) && i_rst_n;
    assign in_fire    = i_in.valid && i_in.ready;
    assign exec_go    = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);
    assign any_hit    = seen[CAPACITY];

    assign do_add = exec_go && (r_cmd == CMD_ADD) && !any_hit
                    && (r_count != CNT_W'(CAPACITY));
    assign do_rem = exec_go && (r_cmd == CMD_REMOVE) && any_hit;

    always_comb begin
        cell_ctl.capture = in_fire;
        cell_ctl.add_en  = do_add;
        cell_ctl.rem_en  = do_rem;
        cell_ctl.count   = r_count;
        cell_ctl.key     = (r_state == S_IDLE) ? i_in.value[ELEM_WIDTH-1:0] : r_key;
    end

    always_comb begin
        n_count = r_count;
        case (r_cmd)
            CMD_ADD: begin
                if (any_hit) begin
                    n_status = ST_MISS;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (any_hit) begin
                    n_status = ST_OK;
                    n_count  = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_MISS;
                end
            end
            default: begin
                n_status = any_hit ? ST_OK : ST_MISS;
            end
        endcase
    end

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_last
            assign cell_next[g] = cell_value[g];
        end else begin : g_mid
            assign cell_next[g] = cell_value[g+1];
        end

        oset_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_index      (IDX_W'(g)),
            .i_next_value (cell_next[g]),
            .i_seen       (seen[g]),
            .o_value      (cell_value[g]),
            .o_seen       (seen[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_EXEC;
                    end
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= t_cmd'(i_in.cmd);
            r_key <= i_in.value[ELEM_WIDTH-1:0];
        end
        if (exec_go) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_empty  <= (n_count == '0);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.entry_count = COUNT_OUT_W'(r_out_count);
    assign o_out.is_empty    = r_out_empty;

endmodule

### sv/oset_checker.sv
// port-level checks of the ordered set table and their bind
`include "ordered_set_table_defines.svh"

module oset_checker import oset_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [STATUS_W-1:0]    i_out_status,
    input logic [COUNT_OUT_W-1:0] i_out_entry_count,
    input logic                   i_out_is_empty
);

    `OSET_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_entry_count))
    `OSET_ASSERT_NOW(a_empty_flag, i_out_valid, i_out_is_empty == (i_out_entry_count == '0))
    `OSET_ASSERT_NOW(a_full_count, i_out_valid && (i_out_status == ST_FULL), i_out_entry_count == COUNT_OUT_W'(CAPACITY))
    `OSET_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind ordered_set_table oset_checker u_oset_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_entry_count (o_out.entry_count),
    .i_out_is_empty    (o_out.is_empty)
);
